[hw/rtl/pfr_pkg.sv]
package pfr_pkg;

	localparam int PHASES_DEF = 16;
	localparam int TAPS_DEF   = 16;

	localparam int SMP_W   = 16;
	localparam int FRAC    = 15;
	localparam int PHASE_W = 18;
	localparam int ONE_Q16 = 65536;
	localparam int MIN_STEP = 1024;

	// APB register map: one register, 18 bits read on the 32-bit bus, word index in paddr[2]
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_PHASE_STEP = 1'b0;

	localparam logic ACT_COEF   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// per-tap control that follows a memory read down the MAC pipeline
	typedef struct packed {
		logic valid;
		logic ok;     // delay entry has been filled; otherwise contributes zero
		logic first;
		logic last;
	} tap_ctl_t;

endpackage

[hw/rtl/polyphase_fractional_resampler_core.sv]
// Complex polyphase fractional resampler, Q1.15 in and out.
// Input channel (in_valid / in_stall): action 0 writes one coefficient pair
// (coef_branch, coef_tap, coef_inphase, coef_quad); action 1
// pushes a complex sample. A sample yields zero or more results on the output
// channel (out_valid / out_stall); last_of_run marks the final one.
// phase_step (APB byte address 0) is the input/output rate ratio, 16 fraction
// bits, clamped below at 1/64; write it only while the block is idle.
// Timing: each result reads TAPS taps from the delay and
// coefficient memories (one tap per cycle through a single shared MAC),
// then drains the MAC pipeline and loads the output register; the sample
// shift-in follows the last result, if any. A sample holds in_stall until
// its results are issued and it is shifted in; a coefficient write does not stall.
// The finished result sits in an output register, so a new item is taken
// while it waits. If the receiver stalls with a result still held, the next
// result waits in the accumulator and the input stays stalled.
// Reset clears phase to zero, phase_step to 1.0 and empties the delay lines
// (tracked by a fill count, no clearing pass). Coefficients are undefined
// until loaded.
module polyphase_fractional_resampler_core import pfr_pkg::*; #(
	parameter int PHASES = PHASES_DEF,
	parameter int TAPS   = TAPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic [3:0]              coef_branch,
	input  logic [3:0]              coef_tap,
	input  logic signed [SMP_W-1:0] coef_inphase,
	input  logic signed [SMP_W-1:0] coef_quad,
	input  logic signed [SMP_W-1:0] sample_re,
	input  logic signed [SMP_W-1:0] sample_im,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] out_re,
	output logic signed [SMP_W-1:0] out_im,
	output logic                    last_of_run,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int BW   = $clog2(PHASES);
	localparam int TW   = $clog2(TAPS);
	localparam int CA_W = BW + TW;
	localparam int FW   = $clog2(TAPS + 1);
	localparam int PM_W = 16 + $clog2(PHASES) + 1;
	localparam int PH_W = PHASE_W + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;

	logic [2:0]         state_q;
	logic [PHASE_W-1:0] phase_step_q;
	logic [PHASE_W-1:0] phase_acc_q;
	logic [PH_W-1:0]    ph_q;
	logic [TW-1:0]      wp_q;
	logic [FW-1:0]      fill_q;
	logic [TW-1:0]      tap_q;
	logic [TW-1:0]      da_q;
	logic [SMP_W-1:0]   smp_re_q;
	logic [SMP_W-1:0]   smp_im_q;
	logic               out_valid_q;
	logic [SMP_W-1:0]   out_re_q;
	logic [SMP_W-1:0]   out_im_q;
	logic               out_last_q;

	logic               in_accept;
	logic               cw_en;
	logic               cfg_we;
	logic               tap_last;
	logic               emit_fire;
	logic [PHASE_W-1:0] step;
	logic [PH_W-1:0]    ph_next;
	logic [PM_W-1:0]    ph_mul;
	logic [BW-1:0]      branch;
	logic [FW:0]        ok_sum;
	tap_ctl_t           mac_ctl;
	logic               mac_done;
	logic [SMP_W-1:0]   mac_re;
	logic [SMP_W-1:0]   mac_im;
	logic [2*SMP_W-1:0] dly_rdata;
	logic [2*SMP_W-1:0] coef_rdata;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cw_en     = in_accept && (action == ACT_COEF) &&
	                   (32'(coef_branch) < PHASES) && (32'(coef_tap) < TAPS);

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PHASE_STEP);
	assign prdata = (paddr[2] == REG_PHASE_STEP) ? 32'(phase_step_q) : '0;

	assign step    = (phase_step_q < PHASE_W'(MIN_STEP)) ? PHASE_W'(MIN_STEP) : phase_step_q;
	assign ph_next = ph_q + PH_W'(step);

	// branch = PHASES-1 - floor(phase*PHASES); phase is below one here
	assign ph_mul = PM_W'(ph_q[15:0]) * PM_W'(PHASES);
	assign branch = BW'(PHASES - 1) - BW'(ph_mul >> 16);

	assign tap_last  = (tap_q == TW'(TAPS - 1));
	assign ok_sum    = (FW + 1)'(tap_q) + (FW + 1)'(fill_q);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign mac_ctl.valid = (state_q == ST_RUN);
	assign mac_ctl.ok    = (state_q == ST_RUN) && (ok_sum >= (FW + 1)'(TAPS));
	assign mac_ctl.first = (tap_q == '0);
	assign mac_ctl.last  = tap_last;

	pfr_ram #(
		.W     (2 * SMP_W),
		.DEPTH (TAPS)
	) u_dly_ram (
		.clk   (clk),
		.we    (state_q == ST_SHIFT),
		.waddr (wp_q),
		.wdata ({smp_re_q, smp_im_q}),
		.raddr (da_q),
		.rdata (dly_rdata)
	);

	pfr_ram #(
		.W     (2 * SMP_W),
		.DEPTH (1 << CA_W)
	) u_coef_ram (
		.clk   (clk),
		.we    (cw_en),
		.waddr ({BW'(coef_branch), TW'(coef_tap)}),
		.wdata ({coef_inphase, coef_quad}),
		.raddr ({branch, tap_q}),
		.rdata (coef_rdata)
	);

	pfr_mac #(
		.TAPS (TAPS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.dly_rdata  (dly_rdata),
		.coef_rdata (coef_rdata),
		.done       (mac_done),
		.res_re     (mac_re),
		.res_im     (mac_im)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_W'(ONE_Q16);
		end else if (cfg_we) begin
			phase_step_q <= pwdata[PHASE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_acc_q <= '0;
			ph_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			tap_q       <= '0;
			da_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (action == ACT_SAMPLE)) begin
						ph_q  <= PH_W'(phase_acc_q);
						tap_q <= '0;
						da_q  <= wp_q;
						if (phase_acc_q < PHASE_W'(ONE_Q16)) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_RUN: begin
					// delay read walks oldest to newest from the write pointer
					tap_q <= tap_q + 1'b1;
					da_q  <= (da_q == TW'(TAPS - 1)) ? '0 : da_q + 1'b1;
					if (tap_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						ph_q  <= ph_next;
						tap_q <= '0;
						da_q  <= wp_q;
						if (ph_next < PH_W'(ONE_Q16)) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					wp_q        <= (wp_q == TW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
					fill_q      <= (fill_q == FW'(TAPS)) ? fill_q : fill_q + 1'b1;
					phase_acc_q <= PHASE_W'(ph_q - PH_W'(ONE_Q16));
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && (action == ACT_SAMPLE)) begin
			smp_re_q <= sample_re;
			smp_im_q <= sample_im;
		end
		if (emit_fire) begin
			out_re_q   <= mac_re;
			out_im_q   <= mac_im;
			out_last_q <= (ph_next >= PH_W'(ONE_Q16));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_re      = out_re_q;
	assign out_im      = out_im_q;
	assign last_of_run = out_last_q;

`ifndef ASSERT_OFF
	// the dot product only runs for phases below one
	a_run_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (ph_q < PH_W'(ONE_Q16)))
		else $error("MAC running with phase at or above one");

	// accumulator completion only while waiting for it
	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("MAC result completed outside drain");

	// a held result is never overwritten while the receiver stalls
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_re_q) &&
		$stable(out_im_q) && $stable(out_last_q)))
		else $error("held result overwritten");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(TAPS))
		else $error("delay fill count out of range");

	// the delay line only changes once all results of the sample are issued
	a_shift_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (ph_q >= PH_W'(ONE_Q16)))
		else $error("sample shifted in before its results");
`endif

endmodule

[hw/rtl/pfr_ram.sv]
module pfr_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/pfr_mac.sv]
module pfr_mac import pfr_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tap_ctl_t                ctl,
	input  logic [2*SMP_W-1:0]      dly_rdata,
	input  logic [2*SMP_W-1:0]      coef_rdata,
	output logic                    done,
	output logic signed [SMP_W-1:0] res_re,
	output logic signed [SMP_W-1:0] res_im
);

	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W  = PROD_W + $clog2(TAPS);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

	tap_ctl_t                  ctl_s1;
	tap_ctl_t                  ctl_s2;
	logic signed [PROD_W-1:0]  prod_re_s2;
	logic signed [PROD_W-1:0]  prod_im_s2;
	logic signed [ACC_W-1:0]   acc_re_q;
	logic signed [ACC_W-1:0]   acc_im_q;
	logic                      done_q;

	logic signed [SMP_W-1:0] d_re;
	logic signed [SMP_W-1:0] d_im;
	logic signed [SMP_W-1:0] c_i;
	logic signed [SMP_W-1:0] c_q;

	assign d_re = dly_rdata[2*SMP_W-1:SMP_W];
	assign d_im = dly_rdata[SMP_W-1:0];
	assign c_i  = coef_rdata[2*SMP_W-1:SMP_W];
	assign c_q  = coef_rdata[SMP_W-1:0];

	function automatic logic [SMP_W-1:0] sat_q15(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] s;
		s = a >>> FRAC;
		if (s > SAT_MAX) begin
			sat_q15 = SAT_MAX[SMP_W-1:0];
		end else if (s < SAT_MIN) begin
			sat_q15 = SAT_MIN[SMP_W-1:0];
		end else begin
			sat_q15 = s[SMP_W-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.ok) begin
			prod_re_s2 <= d_re * c_i;
			prod_im_s2 <= d_im * c_q;
		end else begin
			prod_re_s2 <= '0;
			prod_im_s2 <= '0;
		end
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_re_q <= ACC_W'(prod_re_s2);
				acc_im_q <= ACC_W'(prod_im_s2);
			end else begin
				acc_re_q <= acc_re_q + ACC_W'(prod_re_s2);
				acc_im_q <= acc_im_q + ACC_W'(prod_im_s2);
			end
		end
	end

	assign done   = done_q;
	assign res_re = sat_q15(acc_re_q);
	assign res_im = sat_q15(acc_im_q);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import pfr_pkg::*;

	localparam int NPH = PHASES_DEF;
	localparam int NTAP = TAPS_DEF;
	// margin: twice a result's MAC run and drain, enough to cover a silent item
	localparam int SETTLE_CYCLES = 2 * (NTAP + 4);
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 3000;
	localparam int RAND_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 15;
	localparam logic [PHASE_W-1:0] STEP_MAX = '1;
	localparam logic [ADDR_W-1:0] ADDR_PHASE_STEP = ADDR_W'(REG_PHASE_STEP) << 2;
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);
	localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7fff;
	localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;

	typedef struct packed {
		logic act;
		logic [3:0] branch;
		logic [3:0] tap;
		logic [SMP_W-1:0] ci;
		logic [SMP_W-1:0] cq;
		logic [SMP_W-1:0] sre;
		logic [SMP_W-1:0] sim;
	} item_t;

	typedef struct packed {
		logic [SMP_W-1:0] re;
		logic [SMP_W-1:0] im;
		logic last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_COEF;
	logic [3:0] coef_branch = '0;
	logic [3:0] coef_tap = '0;
	logic signed [SMP_W-1:0] coef_inphase = '0;
	logic signed [SMP_W-1:0] coef_quad = '0;
	logic signed [SMP_W-1:0] sample_re = '0;
	logic signed [SMP_W-1:0] sample_im = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SMP_W-1:0] out_re;
	logic signed [SMP_W-1:0] out_im;
	logic last_of_run;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	polyphase_fractional_resampler_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.coef_branch(coef_branch), .coef_tap(coef_tap),
		.coef_inphase(coef_inphase), .coef_quad(coef_quad),
		.sample_re(sample_re), .sample_im(sample_im),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_re(out_re), .out_im(out_im), .last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// resampler image: coefficient banks, delay lines, phase and step
	logic signed [SMP_W-1:0] bank_i [NPH*NTAP];
	logic signed [SMP_W-1:0] bank_q [NPH*NTAP];
	logic signed [SMP_W-1:0] hist_re [NTAP];
	logic signed [SMP_W-1:0] hist_im [NTAP];
	logic [PHASE_W-1:0] phase_now;
	logic [PHASE_W-1:0] step_now;
	result_t filtered_q [$];

	int n_fail = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	result_t want;

	function automatic void flag(string msg);
		if (n_fail < 10)
			$display("%s", msg);
		n_fail++;
	endfunction

	function automatic logic [SMP_W-1:0] sat16(longint acc);
		longint s;
		s = acc >>> FRAC;	// floor
		if (s > longint'(S_MAX))
			return S_MAX;
		if (s < longint'(S_MIN))
			return S_MIN;
		return s[SMP_W-1:0];
	endfunction

	// update the image with one item and queue the outputs it produces
	function automatic void resample(item_t it);
		int unsigned ph, stp, br;
		int t;
		longint acc_re, acc_im;
		result_t r;
		if (it.act == ACT_COEF) begin
			if (it.branch < NPH && it.tap < NTAP) begin
				bank_i[it.branch*NTAP + it.tap] = it.ci;
				bank_q[it.branch*NTAP + it.tap] = it.cq;
			end
			return;
		end
		stp = (step_now < MIN_STEP) ? MIN_STEP : 32'(step_now);
		ph = 32'(phase_now);
		while (ph < ONE_Q16) begin
			br = NPH - 1 - (ph * NPH) / ONE_Q16;
			acc_re = 0;
			acc_im = 0;
			for (t = 0; t < NTAP; t++) begin
				acc_re += longint'(hist_re[t]) * longint'(bank_i[br*NTAP + t]);
				acc_im += longint'(hist_im[t]) * longint'(bank_q[br*NTAP + t]);
			end
			r.re = sat16(acc_re);
			r.im = sat16(acc_im);
			r.last = (ph + stp >= ONE_Q16);
			filtered_q.push_back(r);
			ph += stp;
		end
		phase_now = PHASE_W'(ph - ONE_Q16);
		for (t = 0; t < NTAP - 1; t++) begin
			hist_re[t] = hist_re[t+1];
			hist_im[t] = hist_im[t+1];
		end
		hist_re[NTAP-1] = it.sre;
		hist_im[NTAP-1] = it.sim;
	endfunction

	function automatic logic [SMP_W-1:0] any16();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? S_MAX : S_MIN;
		return SMP_W'($urandom);
	endfunction

	function automatic item_t coef_item(logic [3:0] b, logic [3:0] t, logic [15:0] ci,
			logic [15:0] cq);
		item_t it;
		it.act = ACT_COEF;
		it.branch = b;
		it.tap = t;
		it.ci = ci;
		it.cq = cq;
		it.sre = SMP_W'($urandom);
		it.sim = SMP_W'($urandom);
		return it;
	endfunction

	function automatic item_t sample_item(logic [15:0] re, logic [15:0] im);
		item_t it;
		it.act = ACT_SAMPLE;
		it.branch = 4'($urandom);
		it.tap = 4'($urandom);
		it.ci = SMP_W'($urandom);
		it.cq = SMP_W'($urandom);
		it.sre = re;
		it.sim = im;
		return it;
	endfunction

	// valid stays high after a transfer; the next call either lowers it or
	// presents the next item
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.act;
		coef_branch <= it.branch;
		coef_tap <= it.tap;
		coef_inphase <= it.ci;
		coef_quad <= it.cq;
		sample_re <= it.sre;
		sample_im <= it.sim;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		resample(it);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [ADDR_W-1:0] a, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (a == ADDR_PHASE_STEP)
			step_now = d[PHASE_W-1:0];
		@(posedge clk);
	endtask

	task automatic reg_check(logic [ADDR_W-1:0] a, logic [31:0] exp_val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== exp_val)
			flag($sformatf("prdata @%0d: want %h got %h", a, exp_val, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_step(logic [31:0] d);
		settle();
		reg_write(ADDR_PHASE_STEP, d);
		reg_check(ADDR_PHASE_STEP, 32'(step_now));
	endtask

	// output side: stall pattern plus the long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				flag($sformatf("unexpected result re=%0d im=%0d last=%0b",
					out_re, out_im, last_of_run));
			end else begin
				want = filtered_q.pop_front();
				if (out_re !== want.re || out_im !== want.im || last_of_run !== want.last)
					flag($sformatf("result: want re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
						$signed(want.re), $signed(want.im), want.last,
						out_re, out_im, last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[polyphase_fractional_resampler_core] ERROR");
				$finish;
			end
		end
	end

	// every coefficient is loaded before any sample can read one
	task automatic test_bank_load();
		int b, t;
		for (b = 0; b < NPH; b++)
			for (t = 0; t < NTAP; t++)
				send_item(coef_item(4'(b), 4'(t), any16(), any16()));
	endtask

	// full-scale taps and samples drive both outputs into both rails
	task automatic test_saturation();
		int k;
		for (k = NTAP / 2; k < NTAP; k++)
			send_item(coef_item(4'(NPH - 1), 4'(k), S_MAX, S_MIN));
		repeat (5) send_item(sample_item(S_MAX, S_MAX));
		repeat (8) send_item(sample_item(S_MIN, S_MIN));
	endtask

	task automatic test_phase_step();
		settle();
		reg_check(ADDR_PHASE_STEP, 32'(step_now));
		reg_write(ADDR_UNMAPPED, $urandom);
		reg_check(ADDR_PHASE_STEP, 32'(step_now));
		// below the minimum step: clamps, 64 results per sample
		set_step(1);
		repeat (2) send_item(sample_item(any16(), any16()));
		// largest step: phase runs above one, so some of the next samples give no result
		set_step(32'(STEP_MAX));
		repeat (4) send_item(sample_item(any16(), any16()));
		set_step(MIN_STEP);
		send_item(sample_item(any16(), any16()));
	endtask

	// receiver holds off while items keep coming, so the input backs up
	task automatic test_backpressure();
		set_step(ONE_Q16);
		send_idle = 0;
		recv_stall = 0;
		hold_req++;
		repeat (24) send_item(sample_item(any16(), any16()));
	endtask

	task automatic test_random();
		int p, i;
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: set_step($urandom_range(20000, 140000));
				1: set_step(32'(STEP_MAX));
				2: set_step(MIN_STEP);
				3: set_step($urandom);
				4: set_step(ONE_Q16);
				5: set_step($urandom_range(MIN_STEP, 8192));
				6: set_step($urandom_range(MIN_STEP, 32'(STEP_MAX)));
				default: set_step($urandom_range(0, MIN_STEP - 1));
			endcase
			case (p % 4)
				0: begin
					send_idle = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle = 56;
					recv_stall = 0;
				end
				2: begin
					send_idle = 0;
					recv_stall = 56;
				end
				default: begin
					send_idle = 10;
					recv_stall = 10;
				end
			endcase
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(99) < 15)
					send_item(coef_item(4'($urandom), 4'($urandom), any16(), any16()));
				else
					send_item(sample_item(any16(), any16()));
			end
		end
	endtask

	initial begin
		phase_now = '0;
		step_now = PHASE_W'(ONE_Q16);
		for (int t = 0; t < NTAP; t++) begin
			hist_re[t] = '0;
			hist_im[t] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bank_load();
		test_saturation();
		test_phase_step();
		test_backpressure();
		test_random();
		send_idle = 0;
		recv_stall = 0;
		settle();
		if (n_fail == 0)
			$display("[polyphase_fractional_resampler_core] OK");
		else
			$display("[polyphase_fractional_resampler_core] ERROR");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_ram.sv
hw/rtl/pfr_mac.sv
hw/rtl/polyphase_fractional_resampler_core.sv
tb/testbench.sv
